>>> design/opox_pkg.sv
// Package for the one-point order crossover block: sizes of the tour stores,
// gene and stream word widths.
// No dependencies.
package opox_pkg;

	localparam int MAX_CITIES = 64;
	localparam int GENE_W     = 6;
	localparam int CITY_SET   = 1 << GENE_W;
	localparam int ADDR_W     = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
	localparam int CNT_W      = $clog2(MAX_CITIES + 1);
	localparam int CMP_W      = (CNT_W > GENE_W) ? CNT_W : GENE_W;
	localparam int S_DATA_W   = ((3 * GENE_W + 7) / 8) * 8;
	localparam int M_DATA_W   = ((GENE_W + 7) / 8) * 8;

	typedef logic [GENE_W-1:0] gene_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  count_t;

endpackage

>>> design/one_point_order_crossover.sv
// One-point order crossover of two parent tours (OX1 style).
// Slave stream: one word per tour position, father and mother gene, cut point on tlast.
// Master stream: one word per child position; tuser flags a bad cut point.
// Depends on opox_pkg.
//
// Usage:
//   Parents stream in on s_*, one word per position, one word per cycle while idle. The
//   word with s_tlast closes both tours and carries the cut point; positions past MAX_CITIES
//   are dropped. The child then streams out on m_*, one word per position, m_tlast on the
//   last one, m_tuser set on every word when the cut is not below the tour length.
//   Emission runs through the father/mother stores, one synchronous read per cycle while
//   no stall holds it: cut reads for the kept prefix (the whole father tour on a bad cut),
//   then one read per mother gene scanned (a skipped gene is read as well), then father
//   reads for any positions left, L to 2*L reads for a child of length L. The last word
//   passes the read register and then the output register; a father tail pass first
//   waits in ST_DRAIN for the read in flight. s_tready is low from the last word until
//   the block is back in ST_IDLE, after the final read of the child has been consumed;
//   the final word may still sit in the output register. Stalls: a low m_tready holds
//   a valid output word and stops the store reads once a gene to emit waits in the read register.
//   Reset: state, counters and prefix bitmap clear; the stores are not cleared.
module one_point_order_crossover
	import opox_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // father_gene, mother_gene, cut_point, zero pad
	input  logic                s_tlast,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // child_gene, zero pad
	output logic                m_tuser,  // bad_cut
	output logic                m_tlast
);

	typedef enum logic [2:0] {ST_IDLE, ST_PREF, ST_SCAN, ST_DRAIN, ST_TAIL} state_t;
	typedef enum logic {RD_FATHER, RD_MOTHER} rd_kind_t;

	gene_t father_mem [MAX_CITIES];
	gene_t mother_mem [MAX_CITIES];

	state_t              state_q;
	count_t              cnt_q, len_q, pref_len_q, emit_cnt_q, scan_left_q;
	addr_t               idx_q, cut_q;
	logic                bad_q;
	logic [CITY_SET-1:0] seen_q;
	logic                rd_valid_s1;
	rd_kind_t            rd_kind_s1;
	gene_t               fd_s1, md_s1;

	gene_t    s_fg, s_mg, s_cut, s1_gene;
	logic     in_acc, wr_en, bad_new, out_free, emit_full;
	logic     s1_emit, s1_consume, out_load, can_issue, rd_en;
	addr_t    rd_addr;
	rd_kind_t rd_kind;
	count_t   len_new;

	assign s_fg  = s_tdata[GENE_W-1:0];
	assign s_mg  = s_tdata[2*GENE_W-1:GENE_W];
	assign s_cut = s_tdata[3*GENE_W-1:2*GENE_W];

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign wr_en    = in_acc && (cnt_q < CNT_W'(MAX_CITIES));
	assign len_new  = wr_en ? cnt_q + CNT_W'(1) : cnt_q;
	assign bad_new  = CMP_W'(s_cut) >= CMP_W'(len_new);

	assign out_free  = !m_tvalid || m_tready;
	assign emit_full = (emit_cnt_q == len_q);

	always_comb begin
		if (rd_kind_s1 == RD_FATHER) begin
			s1_gene = fd_s1;
			s1_emit = 1'b1;
		end else begin
			s1_gene = md_s1;
			s1_emit = !emit_full && !seen_q[md_s1];
		end
	end

	assign s1_consume = rd_valid_s1 && (!s1_emit || out_free);
	assign out_load   = rd_valid_s1 && s1_emit && out_free;
	assign can_issue  = !rd_valid_s1 || s1_consume;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q;
		rd_kind = RD_FATHER;
		case (state_q)
			ST_PREF: rd_en = can_issue;
			ST_SCAN: begin
				rd_en   = can_issue && !emit_full;
				rd_kind = RD_MOTHER;
			end
			ST_TAIL: rd_en = can_issue;
			default: rd_en = 1'b0;
		endcase
	end

	// tour stores, one write port and one registered read port each
	always_ff @(posedge clk) begin
		if (wr_en) begin
			father_mem[cnt_q[ADDR_W-1:0]] <= s_fg;
			mother_mem[cnt_q[ADDR_W-1:0]] <= s_mg;
		end
		if (rd_en) begin
			fd_s1 <= father_mem[rd_addr];
			md_s1 <= mother_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			len_q       <= '0;
			pref_len_q  <= '0;
			emit_cnt_q  <= '0;
			scan_left_q <= '0;
			idx_q       <= '0;
			cut_q       <= '0;
			bad_q       <= 1'b0;
			seen_q      <= '0;
			rd_valid_s1 <= 1'b0;
			rd_kind_s1  <= RD_FATHER;
			m_tvalid    <= 1'b0;
			m_tdata     <= '0;
			m_tuser     <= 1'b0;
			m_tlast     <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_valid_s1 <= 1'b1;
				rd_kind_s1  <= rd_kind;
			end else if (s1_consume) begin
				rd_valid_s1 <= 1'b0;
			end

			if (s1_consume && rd_kind_s1 == RD_FATHER)
				seen_q[fd_s1] <= 1'b1;

			if (out_load) begin
				emit_cnt_q <= emit_cnt_q + CNT_W'(1);
				m_tdata    <= {{(M_DATA_W-GENE_W){1'b0}}, s1_gene};
				m_tuser    <= bad_q;
				m_tlast    <= (emit_cnt_q + CNT_W'(1) == len_q);
				m_tvalid   <= 1'b1;
			end else if (m_tready) begin
				m_tvalid   <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (wr_en)
						cnt_q <= cnt_q + CNT_W'(1);
					if (in_acc && s_tlast) begin
						len_q      <= len_new;
						bad_q      <= bad_new;
						emit_cnt_q <= '0;
						cut_q      <= ADDR_W'(s_cut);
						pref_len_q <= bad_new ? len_new : CNT_W'(s_cut);
						if (bad_new || s_cut != '0) begin
							idx_q   <= '0;
							state_q <= ST_PREF;
						end else begin
							idx_q       <= '0;
							scan_left_q <= len_new;
							state_q     <= ST_SCAN;
						end
					end
				end
				ST_PREF: begin
					if (rd_en) begin
						if (CNT_W'(idx_q) + CNT_W'(1) == pref_len_q) begin
							if (bad_q) begin
								state_q <= ST_DRAIN;
							end else begin
								idx_q       <= cut_q;
								scan_left_q <= len_q;
								state_q     <= ST_SCAN;
							end
						end else begin
							idx_q <= idx_q + ADDR_W'(1);
						end
					end
				end
				ST_SCAN: begin
					if (emit_full) begin
						state_q <= ST_DRAIN;
					end else if (rd_en) begin
						scan_left_q <= scan_left_q - CNT_W'(1);
						if (CNT_W'(idx_q) == len_q - CNT_W'(1))
							idx_q <= '0;
						else
							idx_q <= idx_q + ADDR_W'(1);
						if (scan_left_q == CNT_W'(1))
							state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rd_valid_s1) begin
						if (emit_full) begin
							cnt_q   <= '0;
							seen_q  <= '0;
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= emit_cnt_q[ADDR_W-1:0];
							state_q <= ST_TAIL;
						end
					end
				end
				ST_TAIL: begin
					if (rd_en) begin
						if (CNT_W'(idx_q) + CNT_W'(1) == len_q)
							state_q <= ST_DRAIN;
						else
							idx_q <= idx_q + ADDR_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !rd_valid_s1 && seen_q == '0)
		else $error("idle with read in flight or prefix bitmap set");

	a_emit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> emit_cnt_q < len_q)
		else $error("child gene emitted past tour length");

	a_father_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 && rd_kind_s1 == RD_FATHER |-> !emit_full)
		else $error("father read with child already complete");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> cnt_q <= CNT_W'(MAX_CITIES))
		else $error("stored position count above store depth");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && (emit_cnt_q + CNT_W'(1) == len_q) |=> emit_full)
		else $error("final child word without full count");

endmodule

>>> bench/tb_top.sv
// Self-checking bench for one_point_order_crossover: streams parent tours in,
// predicts every child tour and checks each output word field by field.
// Depends on opox_pkg and the block's RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import opox_pkg::*;

	localparam int IDLE_LIMIT   = 4000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 2 * MAX_CITIES + 16;
	localparam int RANDOM_WORDS = 120;

	typedef struct {
		gene_t father;
		gene_t mother;
		gene_t cut;
		bit    last;
		int    gap;
	} tour_word_t;

	typedef struct {
		gene_t gene;
		bit    bad;
		bit    tail;
	} child_word_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0;  // father_gene, mother_gene, cut_point, zero pad
	logic                s_tlast  = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;        // child_gene, zero pad
	logic                m_tuser;        // bad_cut
	logic                m_tlast;

	tour_word_t  word_queue[$];
	child_word_t child_expect[$];
	gene_t       fa_q[$];
	gene_t       mo_q[$];
	gene_t       father_mem[MAX_CITIES];
	gene_t       mother_mem[MAX_CITIES];
	int          tour_len = 0;

	bit s_taken   = 1'b0;
	bit m_taken   = 1'b0;
	bit rx_hold   = 1'b0;
	bit rx_steady = 1'b0;
	int rx_wait   = 0;

	int idle_cycles   = 0;
	int errors        = 0;
	int words_queued  = 0;
	int words_sent    = 0;
	int tours_sent    = 0;
	int bad_tours     = 0;
	int genes_checked = 0;

	one_point_order_crossover DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_error(input string msg);
		errors++;
		$display("ERROR t=%0t: %s", $time, msg);
	endtask

	// store one position; on the closing word build the whole child tour
	function automatic void predict_child(input gene_t fg, input gene_t mg, input gene_t cut,
			input bit is_last);
		gene_t                child[MAX_CITIES];
		logic [CITY_SET-1:0]  kept;
		child_word_t          w;
		gene_t                g;
		int                   n, pos, src, k;
		bit                   bad;
		if (tour_len < MAX_CITIES) begin
			father_mem[tour_len] = fg;
			mother_mem[tour_len] = mg;
			tour_len++;
		end
		if (!is_last)
			return;
		n = tour_len;
		for (k = 0; k < n; k++)
			child[k] = father_mem[k];
		bad = (int'(cut) >= n);
		if (!bad) begin
			kept = '0;
			for (k = 0; k < int'(cut); k++)
				kept[father_mem[k]] = 1'b1;
			pos = int'(cut);
			for (k = 0; k < n; k++) begin
				src = int'(cut) + k;
				if (src >= n)
					src -= n;
				g = mother_mem[src];
				if (!kept[g]) begin
					if (pos < n)
						child[pos] = g;
					pos++;
				end
			end
		end
		for (k = 0; k < n; k++) begin
			w.gene = child[k];
			w.bad  = bad;
			w.tail = (k == n - 1);
			child_expect = {child_expect, w};
		end
		tours_sent++;
		if (bad)
			bad_tours++;
		tour_len = 0;
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && !s_taken)) begin
			if (word_queue.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (word_queue[0].gap > 0) begin
				word_queue[0].gap--;
				s_tvalid <= 1'b0;
			end else begin
				s_tdata  <= {{(S_DATA_W - 3 * GENE_W){1'b0}}, word_queue[0].cut,
					word_queue[0].mother, word_queue[0].father};
				s_tlast  <= word_queue[0].last;
				s_tvalid <= 1'b1;
				void'(word_queue.pop_front());
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (m_taken) begin
				if ($urandom_range(0, 31) == 0)
					rx_steady = !rx_steady;
				rx_wait = rx_steady ? 0 : $urandom_range(0, 10);
			end
			if (rx_hold || rx_wait > 0) begin
				m_tready <= 1'b0;
				if (!rx_hold)
					rx_wait--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// monitor, checker and watchdog
	always @(posedge clk) begin
		child_word_t want;
		if (arst_n) begin
			s_taken <= s_tvalid && s_tready;
			m_taken <= m_tvalid && m_tready;
			if (s_tvalid && s_tready) begin
				words_sent++;
				predict_child(s_tdata[GENE_W-1:0], s_tdata[2*GENE_W-1:GENE_W],
					s_tdata[3*GENE_W-1:2*GENE_W], s_tlast);
			end
			if (m_tvalid && m_tready) begin
				genes_checked++;
				if (child_expect.size() == 0) begin
					report_error($sformatf("child word %0d with nothing expected", m_tdata));
				end else begin
					want = child_expect.pop_front();
					if (m_tdata[GENE_W-1:0] !== want.gene)
						report_error($sformatf("child_gene got %0d, expected %0d",
							m_tdata[GENE_W-1:0], want.gene));
					if (m_tuser !== want.bad)
						report_error($sformatf("bad_cut got %b, expected %b", m_tuser, want.bad));
					if (m_tlast !== want.tail)
						report_error($sformatf("tlast got %b, expected %b", m_tlast, want.tail));
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic queue_word(input gene_t father, input gene_t mother, input gene_t cut,
			input bit last, input bit steady);
		tour_word_t w;
		w.father = father;
		w.mother = mother;
		w.cut    = cut;
		w.last   = last;
		w.gap    = steady ? 0 : $urandom_range(0, 10);
		word_queue = {word_queue, w};
		words_queued++;
	endtask

	// sends the tour held in fa_q/mo_q; cut field is noise except on the closing word
	task automatic queue_tour(input gene_t cut, input bit steady);
		int k, n;
		n = fa_q.size();
		for (k = 0; k < n; k++)
			queue_word(fa_q[k], mo_q[k], (k == n - 1) ? cut : gene_t'($urandom),
				k == n - 1, steady);
		fa_q.delete();
		mo_q.delete();
	endtask

	// mostly permutations; some tours with random mother genes, a few with random father genes too
	task automatic queue_random_tour(input int n, input int cut_sel, input bit steady);
		gene_t pool[CITY_SET];
		gene_t tmp;
		gene_t cut;
		int    c, k, j, kind, span;
		for (c = 0; c < CITY_SET; c++)
			pool[c] = gene_t'(c);
		for (c = CITY_SET - 1; c > 0; c--) begin
			j = $urandom_range(0, c);
			tmp = pool[c];
			pool[c] = pool[j];
			pool[j] = tmp;
		end
		kind = $urandom_range(0, 7);
		for (k = 0; k < n; k++)
			fa_q = {fa_q, (kind == 0) ? gene_t'($urandom) : pool[k % CITY_SET]};
		for (k = 0; k < n; k++)
			mo_q = {mo_q, (kind <= 1) ? gene_t'($urandom) : fa_q[k]};
		if (kind > 1) begin
			for (k = n - 1; k > 0; k--) begin
				j = $urandom_range(0, k);
				tmp = mo_q[k];
				mo_q[k] = mo_q[j];
				mo_q[j] = tmp;
			end
		end
		span = (n < MAX_CITIES) ? n : MAX_CITIES;
		if (cut_sel >= 0)
			cut = gene_t'(cut_sel);
		else if (span < CITY_SET && $urandom_range(0, 5) == 0)
			cut = gene_t'($urandom_range(span, CITY_SET - 1));
		else
			cut = gene_t'($urandom_range(0, span - 1));
		queue_tour(cut, steady);
	endtask

	task automatic wait_drained();
		while (words_sent < words_queued || child_expect.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	initial begin
		int random_start;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// plain permutation
		fa_q = '{5, 9, 2};           mo_q = '{2, 5, 9};           queue_tour(1, 1'b0);
		// no kept prefix: child is the mother
		fa_q = '{0, 1, 2, 3};        mo_q = '{3, 2, 1, 0};        queue_tour(0, 1'b1);
		// cut equal to length: copy of father, flagged
		fa_q = '{63, 0, 63};         mo_q = '{0, 63, 0};          queue_tour(3, 1'b0);
		// single position, all fields at max
		fa_q = '{63};                mo_q = '{63};                queue_tour(63, 1'b0);
		fa_q = '{0};                 mo_q = '{42};                queue_tour(0, 1'b1);
		// repeated mother genes overrun the tour
		fa_q = '{7, 7, 3, 12, 20};   mo_q = '{7, 30, 30, 3, 1};   queue_tour(2, 1'b0);
		// too few fresh mother genes: tail keeps father
		fa_q = '{1, 2, 3, 4};        mo_q = '{1, 2, 3, 1};        queue_tour(2, 1'b0);
		wait_drained();

		// long receiver stall: block fills and stops taking words
		rx_hold = 1'b1;
		queue_random_tour(8, -1, 1'b1);
		queue_random_tour(8, -1, 1'b1);
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold = 1'b0;
		wait_drained();

		random_start = words_queued;
		// over-long tour, capped at the store depth, largest cut
		queue_random_tour(MAX_CITIES + 3, CITY_SET - 1, 1'b0);
		while (words_queued - random_start < RANDOM_WORDS)
			queue_random_tour($urandom_range(1, 12), -1, $urandom_range(0, 3) == 0);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (child_expect.size() != 0)
			report_error($sformatf("%0d child words never arrived", child_expect.size()));

		$display("Sent %0d parent words in %0d tours (%0d with an out-of-range cut),",
			words_sent, tours_sent, bad_tours);
		$display("checked %0d child words; %0d mismatches.", genes_checked, errors);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
